// ----- rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the rtl of the convolution unit
// needs a clock named clock and a synchronous reset named reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define C3C_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define C3C_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define C3C_ASSERT(lbl, prop, msg)
`define C3C_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/c3c_pkg.sv -----
// c3c_pkg: constants, register codes and shared types of the 3x3 convolution unit
// no dependencies; imported by every module of the block
package c3c_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int OUT_POS_W = 10;

   localparam int PIX_W  = 8;
   localparam int NCH    = 3;
   localparam int PXL_W  = NCH * PIX_W;
   localparam int NTAP   = 9;
   localparam int COEF_W = 12;
   localparam int PROD_W = COEF_W + PIX_W;
   localparam int CSUM_W = 24;
   localparam int TSUM_W = 25;

   localparam int KCOEF_W    = 16;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int DIM_W      = 11;
   localparam int CNT_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_TOP = 3'd0,
      CSR_KERNEL_MID = 3'd1,
      CSR_KERNEL_BOT = 3'd2,
      CSR_WIDTH      = 3'd3,
      CSR_HEIGHT     = 3'd4,
      CSR_CHANNELS   = 3'd5,
      CSR_KEEP       = 3'd6
   } csr_idx_type;

   typedef logic [PXL_W-1:0] pixel_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   // live configuration, already saturated to the legal ranges
   typedef struct packed {
      coef_type [NTAP-1:0] coef;
      logic [COL_W:0]      width;
      logic [ROW_W:0]      height;
      logic [CNT_W-1:0]    chan_count;
      logic                keep;
   } cfg_type;

   // one output position handed from the window to the multiply-add datapath
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [COL_W-1:0]     x;
      logic [ROW_W-1:0]     y;
      logic [COL_W-1:0]     c;
      logic [ROW_W-1:0]     r;
      pixel_type [NTAP-1:0] win;
   } tap_req_type;

endpackage

// ----- rtl/c3c_csr.sv -----
// c3c_csr: configuration registers with saturation applied at write time
// depends on c3c_pkg
module c3c_csr
   import c3c_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   localparam int COEF_MAX   = 2 ** (COEF_W - 1) - 1;
   localparam int COEF_MIN   = -(2 ** (COEF_W - 1));
   localparam int COEF_ONE   = 2 ** 8;
   localparam int CENTER_TAP = 4;   // middle row, center column

   cfg_type cfg_ff, cfg_in;
   logic [DIM_W-1:0] raw_dim;

   function automatic coef_type sat_coef(input logic [KCOEF_W-1:0] raw);
      logic signed [KCOEF_W-1:0] v;
      coef_type res;
      v = $signed(raw);
      if (v > KCOEF_W'(COEF_MAX)) begin
         res = COEF_W'(COEF_MAX);
      end else if (v < KCOEF_W'(COEF_MIN)) begin
         res = COEF_W'(COEF_MIN);
      end else begin
         res = v[COEF_W-1:0];
      end
      return res;
   endfunction

   // identity kernel, largest frame, all channels kept apart
   function automatic cfg_type cfg_reset();
      cfg_type res;
      res                  = '0;
      res.coef[CENTER_TAP] = COEF_W'(COEF_ONE);
      res.width            = (COL_W+1)'(MAX_WIDTH);
      res.height           = (ROW_W+1)'(MAX_HEIGHT);
      res.chan_count       = CNT_W'(NCH);
      res.keep             = 1'b1;
      return res;
   endfunction

   assign raw_dim = csr_wdata[DIM_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KERNEL_TOP, CSR_KERNEL_MID, CSR_KERNEL_BOT: begin
               for (int j = 0; j < 3; j++) begin
                  cfg_in.coef[{1'b0, csr_index} * 4'd3 + 4'(j)] =
                     sat_coef(csr_wdata[KCOEF_W*j +: KCOEF_W]);
               end
            end
            CSR_WIDTH: begin
               if (raw_dim < 2) begin
                  cfg_in.width = (COL_W+1)'(2);
               end else if (32'(raw_dim) > MAX_WIDTH) begin
                  cfg_in.width = (COL_W+1)'(MAX_WIDTH);
               end else begin
                  cfg_in.width = (COL_W+1)'(raw_dim);
               end
            end
            CSR_HEIGHT: begin
               if (raw_dim < 2) begin
                  cfg_in.height = (ROW_W+1)'(2);
               end else if (32'(raw_dim) > MAX_HEIGHT) begin
                  cfg_in.height = (ROW_W+1)'(MAX_HEIGHT);
               end else begin
                  cfg_in.height = (ROW_W+1)'(raw_dim);
               end
            end
            CSR_CHANNELS: begin
               // zero channels behaves as one
               cfg_in.chan_count = (csr_wdata[CNT_W-1:0] == '0) ?
                                   CNT_W'(1) : csr_wdata[CNT_W-1:0];
            end
            CSR_KEEP: begin
               cfg_in.keep = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset();
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/c3c_window.sv -----
// c3c_window: line memory, 3x3 window, raster counters and per-pixel emit sequencing
// depends on c3c_pkg and assert_macros.svh
`include "assert_macros.svh"
module c3c_window
   import c3c_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_chan_a,
   input  logic [PIX_W-1:0] req_chan_b,
   input  logic [PIX_W-1:0] req_chan_c,
   input  logic             tap_ready,
   output tap_req_type      tap
);

   // each entry holds {row r-2, row r-1} for one column
   logic [2*PXL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PXL_W-1:0] rd_data_ff;
   logic [COL_W-1:0]   rd_addr;

   logic [COL_W-1:0] col_ff, col_in, col_next, cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] row_ff, row_in, row_next, cur_row_ff, cur_row_in;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic             col_wrap, at_right, at_bottom;

   pixel_type [NTAP-1:0] win_ff, win_in;
   pixel_type            pix_in;

   logic       busy_ff, busy_in;
   logic [3:0] mask_ff, mask_in, mask_new, mask_rest, pick;
   logic       accept, issue, last_one;

   assign pix_in = {req_chan_c, req_chan_b, req_chan_a};
   assign accept = req_valid && req_ready;

   // raster position bookkeeping
   assign col_inc   = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_inc   = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign col_wrap  = col_inc >= cfg.width;
   assign at_right  = col_inc == cfg.width;
   assign at_bottom = row_inc == cfg.height;
   assign col_next  = col_wrap ? '0 : col_inc[COL_W-1:0];
   assign row_next  = !col_wrap ? row_ff :
                      ((row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0]);

   // results owed: above-left, above, left (bottom row), current (bottom-right)
   assign mask_new = {at_bottom && at_right,
                      at_bottom && (col_ff != '0),
                      (row_ff != '0) && at_right,
                      (row_ff != '0) && (col_ff != '0)};

   assign mask_rest = mask_ff & (mask_ff - 4'd1);
   assign pick      = mask_ff & ~mask_rest;
   assign last_one  = mask_rest == '0;
   assign issue     = busy_ff && tap_ready;
   assign req_ready = !busy_ff || (tap_ready && last_one);

   // prefetch the column of the next pixel; the write never hits that column
   assign rd_addr = reset ? '0 : (accept ? col_next : col_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= {rd_data_ff[PXL_W-1:0], pix_in};
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      win_in     = win_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      busy_in    = busy_ff;
      mask_in    = mask_ff;
      if (accept) begin
         col_in     = col_next;
         row_in     = row_next;
         cur_col_in = col_ff;
         cur_row_in = row_ff;
         for (int i = 0; i < 3; i++) begin
            win_in[i*3]     = win_ff[i*3+1];
            win_in[i*3 + 1] = win_ff[i*3+2];
         end
         win_in[2] = rd_data_ff[2*PXL_W-1:PXL_W];
         win_in[5] = rd_data_ff[PXL_W-1:0];
         win_in[8] = pix_in;
         busy_in   = mask_new != '0;
         mask_in   = mask_new;
      end else if (issue) begin
         busy_in = !last_one;
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         win_ff  <= '0;
         busy_ff <= 1'b0;
         mask_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         win_ff  <= win_in;
         busy_ff <= busy_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff <= cur_col_in;
      cur_row_ff <= cur_row_in;
   end

   always_comb begin
      tap       = '0;
      tap.valid = busy_ff;
      tap.last  = last_one;
      tap.c     = cur_col_ff;
      tap.r     = cur_row_ff;
      tap.win   = win_ff;
      tap.x     = (pick[1] || pick[3]) ? cur_col_ff : cur_col_ff - COL_W'(1);
      tap.y     = (pick[0] || pick[1]) ? cur_row_ff - ROW_W'(1) : cur_row_ff;
   end

   `C3C_ASSERT(a_busy_has_work, busy_ff |-> (mask_ff != '0), "busy with no result owed")
   `C3C_ASSERT(a_col_moves, accept |=> (col_ff != $past(col_ff)), "column did not advance")
   `C3C_ASSERT(a_pos_holds, !accept |=> ($stable(col_ff) && $stable(row_ff)), "position moved")
   `C3C_ASSERT(a_stall_holds, (busy_ff && !tap_ready) |=> (busy_ff && $stable(mask_ff)), "lost work")
   `C3C_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy_ff && col_ff == '0), "reset not idle")

endmodule

// ----- rtl/c3c_mac.sv -----
// c3c_mac: border tap selection, 27 products, channel sums and the result register
// depends on c3c_pkg
module c3c_mac
   import c3c_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  tap_req_type               tap,
   output logic                      tap_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [OUT_POS_W-1:0]      rsp_out_col,
   output logic [OUT_POS_W-1:0]      rsp_out_row,
   output logic signed [TSUM_W-1:0]  rsp_sum_a,
   output logic signed [CSUM_W-1:0]  rsp_sum_b,
   output logic signed [CSUM_W-1:0]  rsp_sum_c,
   output logic                      rsp_last_in_run
);

   localparam int POS_SW = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;

   // clamp to the frame, then to the three window rows or columns held
   function automatic logic [1:0] win_sel(input logic signed [POS_SW-1:0] pos,
                                          input logic signed [POS_SW-1:0] lim,
                                          input logic signed [POS_SW-1:0] base);
      logic signed [POS_SW-1:0] v;
      logic signed [POS_SW-1:0] d;
      logic [1:0] res;
      v = (pos < 0) ? '0 : ((pos > lim) ? lim : pos);
      d = v - base;
      if (d < 0) begin
         res = 2'd0;
      end else if (d > 2) begin
         res = 2'd2;
      end else begin
         res = d[1:0];
      end
      return res;
   endfunction

   logic [1:0] wr [3];
   logic [1:0] wc [3];
   logic signed [POS_SW-1:0] w_lim, h_lim, c_base, r_base;
   pixel_type tap_pix [NTAP];
   logic [PIX_W-1:0] chan_val [NCH][NTAP];
   logic signed [PROD_W:0] mult_full [NCH][NTAP];

   logic signed [PROD_W-1:0] prod_ff [NCH][NTAP];
   logic signed [PROD_W-1:0] prod_in [NCH][NTAP];
   logic p_valid_ff, p_valid_in, p_last_ff, p_last_in;
   logic [COL_W-1:0] p_col_ff, p_col_in;
   logic [ROW_W-1:0] p_row_ff, p_row_in;

   logic signed [CSUM_W-1:0] chan_sum [NCH];
   logic signed [TSUM_W-1:0] total;

   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [OUT_POS_W-1:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic signed [TSUM_W-1:0] rsp_a_ff, rsp_a_in;
   logic signed [CSUM_W-1:0] rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;

   logic rsp_take, p_adv;

   assign rsp_take  = !rsp_valid_ff || rsp_ready;
   assign p_adv     = !p_valid_ff || rsp_take;
   assign tap_ready = p_adv;

   assign w_lim  = POS_SW'(cfg.width) - POS_SW'(1);
   assign h_lim  = POS_SW'(cfg.height) - POS_SW'(1);
   assign c_base = POS_SW'(tap.c) - POS_SW'(2);
   assign r_base = POS_SW'(tap.r) - POS_SW'(2);

   // stage one: pick taps and multiply
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         wc[j] = win_sel(POS_SW'(tap.x) + POS_SW'(j) - POS_SW'(1), w_lim, c_base);
         wr[j] = win_sel(POS_SW'(tap.y) + POS_SW'(j) - POS_SW'(1), h_lim, r_base);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tap_pix[i*3 + j] = tap.win[{2'b00, wr[i]} * 4'd3 + {2'b00, wc[j]}];
         end
      end
      for (int k = 0; k < NCH; k++) begin
         for (int t = 0; t < NTAP; t++) begin
            chan_val[k][t]  = (CNT_W'(k) < cfg.chan_count) ?
                              tap_pix[t][PIX_W*k +: PIX_W] : '0;
            mult_full[k][t] = cfg.coef[t] * $signed({1'b0, chan_val[k][t]});
            prod_in[k][t]   = mult_full[k][t][PROD_W-1:0];
         end
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      p_last_in  = p_last_ff;
      p_col_in   = p_col_ff;
      p_row_in   = p_row_ff;
      if (p_adv) begin
         p_valid_in = tap.valid;
         p_last_in  = tap.last;
         p_col_in   = tap.x;
         p_row_in   = tap.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_last_ff <= p_last_in;
      p_col_ff  <= p_col_in;
      p_row_ff  <= p_row_in;
      if (p_adv) begin
         prod_ff <= prod_in;
      end
   end

   // stage two: sum the nine products of each channel, then the channel sums into one total
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         chan_sum[k] = '0;
         for (int t = 0; t < NTAP; t++) begin
            chan_sum[k] = chan_sum[k] + CSUM_W'(prod_ff[k][t]);
         end
      end
      total = TSUM_W'(chan_sum[0]) + TSUM_W'(chan_sum[1]) + TSUM_W'(chan_sum[2]);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      if (rsp_take) begin
         rsp_valid_in = p_valid_ff;
         rsp_last_in  = p_last_ff;
         rsp_col_in   = OUT_POS_W'(p_col_ff);
         rsp_row_in   = OUT_POS_W'(p_row_ff);
         rsp_a_in     = cfg.keep ? TSUM_W'(chan_sum[0]) : total;
         rsp_b_in     = cfg.keep ? chan_sum[1] : '0;
         rsp_c_in     = cfg.keep ? chan_sum[2] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= rsp_last_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_c_ff    <= rsp_c_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_sum_a       = rsp_a_ff;
   assign rsp_sum_b       = rsp_b_ff;
   assign rsp_sum_c       = rsp_c_ff;
   assign rsp_last_in_run = rsp_last_ff;

endmodule

// ----- rtl/clamped_3x3_convolution_unit.sv -----
// clamped_3x3_convolution_unit: top level of the streaming 3x3 convolution unit
// depends on c3c_pkg, c3c_csr, c3c_window and c3c_mac
//
// Pixels enter in raster order on the req_ beat, up to three 8-bit channels each, and
// every output pixel of the frame leaves on the rsp_ beat tagged with its column and
// row, weighted by one signed Q4.8 3x3 kernel (no flip) with edge pixels repeated past
// the frame border. A result leaves as soon as its lower-right neighbor has arrived;
// right-column and bottom-row results are sent early, so a pixel causes zero to four
// results (end of a row two, last pixel of the frame four), row above first, left
// first, the last one marked by rsp_last_in_run. A pixel that causes at most one
// result is taken every clock unless the output is stalled; one causing n results holds the
// input until all have gone to the single multiply-add datapath, which computes one
// result per clock when not stalled. The line memory needs no clearing pass after
// reset: unwritten entries are read but never picked as taps. The user must write
// configuration on the csr_ port only while no results are outstanding; the block
// does not enforce it. Changes act on the next pixel.
module clamped_3x3_convolution_unit
   import c3c_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // pixel input beat
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIX_W-1:0]         req_chan_a,
   input  logic [PIX_W-1:0]         req_chan_b,
   input  logic [PIX_W-1:0]         req_chan_c,
   // result beat
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OUT_POS_W-1:0]     rsp_out_col,
   output logic [OUT_POS_W-1:0]     rsp_out_row,
   output logic signed [TSUM_W-1:0] rsp_sum_a,
   output logic signed [CSUM_W-1:0] rsp_sum_b,
   output logic signed [CSUM_W-1:0] rsp_sum_c,
   output logic                     rsp_last_in_run,
   // register writes
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cfg_type     cfg;        // saturated kernel, frame size and channel mode
   tap_req_type tap;        // one output position plus its window snapshot
   logic        tap_ready;  // datapath can take the next position

   // kernel coefficients are clipped to Q4.8, frame size to 2..max, zero channels to one
   c3c_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // line memory and window advance once per accepted pixel; the window is held
   // until every result that pixel owes has been handed on
   c3c_window u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_chan_a (req_chan_a),
      .req_chan_b (req_chan_b),
      .req_chan_c (req_chan_c),
      .tap_ready  (tap_ready),
      .tap        (tap)
   );

   // products registered, then channel sums into the result register
   c3c_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .tap             (tap),
      .tap_ready       (tap_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_sum_a       (rsp_sum_a),
      .rsp_sum_b       (rsp_sum_b),
      .rsp_sum_c       (rsp_sum_c),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

// ----- verif/clamped_3x3_convolution_unit_tb.sv -----
`timescale 1ns / 100ps
// clamped_3x3_convolution_unit_tb: self-checking bench of the streaming 3x3 convolution unit
// depends on c3c_pkg and the rtl of clamped_3x3_convolution_unit; needs no files or arguments
module clamped_3x3_convolution_unit_tb;
   import c3c_pkg::*;

   localparam int IDLE_PERCENT  = 36;
   localparam int SETTLE_CYCLES = 8;     // margin for the window, product and result registers to drain
   localparam int STALL_LIMIT   = 3000;  // cycles with no beat or register write before giving up
   localparam int HOLD_CYCLES   = 250;
   localparam int HOLD_BACKLOG  = 40;    // pixels waiting before the long hold-off starts
   localparam int PRESS_WIDTH   = 24;
   localparam int RANDOM_PIXELS = 120;
   localparam int COEF_MAX      = (1 << (COEF_W - 1)) - 1;
   localparam int COEF_MIN      = -(1 << (COEF_W - 1));

   typedef struct packed {
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] c;
   } pixel_t;

   // one output pixel, laid out like the rsp_ ports
   typedef struct packed {
      logic [OUT_POS_W-1:0]     col;
      logic [OUT_POS_W-1:0]     row;
      logic signed [TSUM_W-1:0] sum_a;
      logic signed [CSUM_W-1:0] sum_b;
      logic signed [CSUM_W-1:0] sum_c;
      logic                     last;
   } filtered_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_chan_a = '0;
   logic [PIX_W-1:0]         req_chan_b = '0;
   logic [PIX_W-1:0]         req_chan_c = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [OUT_POS_W-1:0]     rsp_out_col;
   logic [OUT_POS_W-1:0]     rsp_out_row;
   logic signed [TSUM_W-1:0] rsp_sum_a;
   logic signed [CSUM_W-1:0] rsp_sum_b;
   logic signed [CSUM_W-1:0] rsp_sum_c;
   logic                     rsp_last_in_run;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // register image as last written to the block, reset values first
   logic [CSR_DATA_W-1:0] kernel_rows [3] = '{48'h0, 48'h0000_0100_0000, 48'h0};
   logic [DIM_W-1:0]      width_reg  = DIM_W'(MAX_WIDTH);
   logic [DIM_W-1:0]      height_reg = DIM_W'(MAX_HEIGHT);
   logic [CNT_W-1:0]      chans_reg  = CNT_W'(NCH);
   logic                  keep_reg   = 1'b1;

   // line memory, tap window and raster position of the next pixel
   logic [PXL_W-1:0] row_above     [MAX_WIDTH] = '{default: '0};
   logic [PXL_W-1:0] row_two_above [MAX_WIDTH] = '{default: '0};
   logic [PXL_W-1:0] tap_window    [NTAP]      = '{default: '0};
   int               col_pos = 0;
   int               row_pos = 0;

   pixel_t    pixels_to_send [$];
   filtered_t filtered_due   [$];

   int   error_count  = 0;
   int   random_count = 0;
   int   hold_left    = 0;
   int   quiet_cycles = 0;
   logic hold_done    = 1'b0;
   logic steady_flow  = 1'b0;   // both sides stop idling while set

   clamped_3x3_convolution_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_chan_a      (req_chan_a),
      .req_chan_b      (req_chan_b),
      .req_chan_c      (req_chan_c),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_sum_a       (rsp_sum_a),
      .rsp_sum_b       (rsp_sum_b),
      .rsp_sum_c       (rsp_sum_c),
      .rsp_last_in_run (rsp_last_in_run),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // coefficient of kernel row kr, column kc, saturated to signed q4.8
   function automatic int tap_weight(int kr, int kc);
      logic signed [KCOEF_W-1:0] raw;
      int v;
      raw = kernel_rows[kr][KCOEF_W*kc +: KCOEF_W];
      v = int'(raw);
      return clip(v, COEF_MIN, COEF_MAX);
   endfunction

   // weighted sum for output (x, y) while the newest pixel sits at (c, r)
   function automatic filtered_t weigh_window(int x, int y, int c, int r, int w, int h);
      int acc [NCH];
      int nch, wr, wc, total;
      logic [PXL_W-1:0] px;
      filtered_t res;
      acc = '{default: 0};
      nch = (chans_reg == 0) ? 1 : int'(chans_reg);
      for (int i = 0; i < 3; i++) begin
         // border taps fall back on the nearest pixel inside the frame
         wr = clip(clip(y - 1 + i, 0, h - 1) - (r - 2), 0, 2);
         for (int j = 0; j < 3; j++) begin
            wc = clip(clip(x - 1 + j, 0, w - 1) - (c - 2), 0, 2);
            px = tap_window[wr*3 + wc];
            for (int k = 0; k < NCH; k++)
               if (k < nch) acc[k] += tap_weight(i, j) * int'(px[PIX_W*k +: PIX_W]);
         end
      end
      res.col = OUT_POS_W'(x);
      res.row = OUT_POS_W'(y);
      if (keep_reg) begin
         res.sum_a = TSUM_W'(acc[0]);
         res.sum_b = CSUM_W'(acc[1]);
         res.sum_c = CSUM_W'(acc[2]);
      end else begin
         total = acc[0] + acc[1] + acc[2];
         res.sum_a = TSUM_W'(total);
         res.sum_b = '0;
         res.sum_c = '0;
      end
      res.last = 1'b0;
      return res;
   endfunction

   // takes one accepted pixel and queues every output pixel it completes
   function automatic void filter_pixel(pixel_t p);
      int w, h, c, r, n;
      filtered_t outs [4];
      w = clip(width_reg, 2, MAX_WIDTH);
      h = clip(height_reg, 2, MAX_HEIGHT);
      c = col_pos % MAX_WIDTH;
      r = row_pos;
      n = 0;
      for (int i = 0; i < 3; i++) begin
         tap_window[i*3]     = tap_window[i*3 + 1];
         tap_window[i*3 + 1] = tap_window[i*3 + 2];
      end
      tap_window[2] = row_two_above[c];
      tap_window[5] = row_above[c];
      tap_window[8] = {p.c, p.b, p.a};
      row_two_above[c] = row_above[c];
      row_above[c]     = {p.c, p.b, p.a};
      // row above first, then the current row; right column and bottom row go early
      if (r >= 1 && c >= 1) begin
         outs[n] = weigh_window(c - 1, r - 1, c, r, w, h);
         n++;
      end
      if (r >= 1 && c == w - 1) begin
         outs[n] = weigh_window(c, r - 1, c, r, w, h);
         n++;
      end
      if (r == h - 1 && c >= 1) begin
         outs[n] = weigh_window(c - 1, r, c, r, w, h);
         n++;
      end
      if (r == h - 1 && c == w - 1) begin
         outs[n] = weigh_window(c, r, c, r, w, h);
         n++;
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) outs[i].last = 1'b1;
         filtered_due.push_back(outs[i]);
      end
      // wrap column and row, also when a register change left them past the edge
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // pixels still missing before the raster position is back at the frame origin
   function automatic int pixels_left_in_frame();
      int w, h, n, nr;
      w = clip(width_reg, 2, MAX_WIDTH);
      h = clip(height_reg, 2, MAX_HEIGHT);
      if (col_pos == 0 && row_pos == 0) return 0;
      n = (col_pos >= w) ? 1 : w - col_pos;
      nr = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      if (nr != 0) n += (h - nr) * w;
      return n;
   endfunction

   function automatic void queue_random(int n);
      pixel_t px;
      for (int i = 0; i < n; i++) begin
         px = PXL_W'($urandom);
         if ($urandom_range(7) == 0) px.a = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(7) == 0) px.b = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(7) == 0) px.c = $urandom_range(1) ? 8'hFF : 8'h00;
         pixels_to_send.push_back(px);
      end
      random_count += n;
   endfunction

   // mix of in-range, just-out-of-range and raw coefficients
   function automatic logic [CSR_DATA_W-1:0] random_kernel_row();
      logic [CSR_DATA_W-1:0] rowbits;
      logic [KCOEF_W-1:0] coef;
      for (int j = 0; j < 3; j++) begin
         case ($urandom_range(3))
            0: coef = KCOEF_W'($urandom);
            3: coef = $urandom_range(1) ? 16'h0800 : 16'hF7FF;
            default: coef = KCOEF_W'($urandom_range(0, 4095) - 2048);
         endcase
         rowbits[KCOEF_W*j +: KCOEF_W] = coef;
      end
      return rowbits;
   endfunction

   // a narrow register value with random junk above it half the time
   function automatic logic [CSR_DATA_W-1:0] with_junk(int unsigned v, int bits);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'(v);
      if ($urandom_range(1)) d |= CSR_DATA_W'({$urandom, $urandom} << bits);
      return d;
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_KERNEL_TOP: kernel_rows[0] = data;
         CSR_KERNEL_MID: kernel_rows[1] = data;
         CSR_KERNEL_BOT: kernel_rows[2] = data;
         CSR_WIDTH:      width_reg = data[DIM_W-1:0];
         CSR_HEIGHT:     height_reg = data[DIM_W-1:0];
         CSR_CHANNELS:   chans_reg = data[CNT_W-1:0];
         CSR_KEEP:       keep_reg = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_kernel(logic [CSR_DATA_W-1:0] top, logic [CSR_DATA_W-1:0] mid,
                             logic [CSR_DATA_W-1:0] bot);
      write_reg(CSR_KERNEL_TOP, top);
      write_reg(CSR_KERNEL_MID, mid);
      write_reg(CSR_KERNEL_BOT, bot);
   endtask

   // block idle: all pixels sent, all results back, pipeline flushed
   task automatic settle();
      while (pixels_to_send.size() != 0 || req_valid || filtered_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // pixel driver: new beat whenever the slot frees up and this cycle is not idle
   always @(posedge clock) begin : pixel_driver
      pixel_t px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) filter_pixel({req_chan_a, req_chan_b, req_chan_c});
         if (!req_valid || req_ready) begin
            if (pixels_to_send.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
               px = pixels_to_send.pop_front();
               req_chan_a <= px.a;
               req_chan_b <= px.b;
               req_chan_c <= px.c;
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // result monitor: compares each beat with the oldest predicted output pixel
   always @(posedge clock) begin : result_monitor
      filtered_t got;
      filtered_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_col, rsp_out_row, rsp_sum_a, rsp_sum_b, rsp_sum_c, rsp_last_in_run};
            if (filtered_due.size() == 0) begin
               $error("result beat col %0d row %0d with no output pixel pending",
                      got.col, got.row);
               error_count++;
            end else begin
               want = filtered_due.pop_front();
               check_field("rsp_out_col", want.col, got.col);
               check_field("rsp_out_row", want.row, got.row);
               check_field("rsp_sum_a", $signed(want.sum_a), $signed(got.sum_a));
               check_field("rsp_sum_b", $signed(want.sum_b), $signed(got.sum_b));
               check_field("rsp_sum_c", $signed(want.sum_c), $signed(got.sum_c));
               check_field("rsp_last_in_run", want.last, got.last);
            end
         end
         // one long hold-off while plenty of pixels wait, so the input backs up
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_valid && pixels_to_send.size() > HOLD_BACKLOG) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles without any beat or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("clamped_3x3_convolution_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int w, h, frames, cut;
      pixel_t px;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // largest positive weights, total over three white channels
      set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      write_reg(CSR_WIDTH, 2);
      write_reg(CSR_HEIGHT, 2);
      write_reg(CSR_CHANNELS, 3);
      write_reg(CSR_KEEP, 0);
      repeat (4) pixels_to_send.push_back({3{8'hFF}});
      settle();

      // most negative weights, per-channel sums
      set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      write_reg(CSR_KEEP, 1);
      repeat (4) pixels_to_send.push_back({3{8'hFF}});
      settle();

      // 3x3 frame, two channels, coefficients on both sides of the saturation points
      set_kernel({16'h0100, 16'hF800, 16'h0800}, {16'hF7FF, 16'h07FF, 16'hFFFF},
                 {16'hFF00, 16'h0000, 16'h0001});
      write_reg(CSR_WIDTH, 3);
      write_reg(CSR_HEIGHT, 3);
      write_reg(CSR_CHANNELS, 2);
      for (int i = 0; i < 9; i++) begin
         px.a = i[0] ? 8'hFF : 8'h00;
         px.b = i[0] ? 8'h00 : 8'hFF;
         px.c = 8'h5A + 8'(i * 29);
         pixels_to_send.push_back(px);
      end
      settle();

      // frame size below the minimum and channel count zero both act as the minimum
      write_reg(CSR_WIDTH, 1);
      write_reg(CSR_HEIGHT, 0);
      write_reg(CSR_CHANNELS, 0);
      write_reg(CSR_KEEP, 0);
      pixels_to_send.push_back({8'h80, 8'h7F, 8'h01});
      pixels_to_send.push_back({8'h01, 8'hFE, 8'h80});
      pixels_to_send.push_back({8'h7F, 8'h00, 8'hFF});
      pixels_to_send.push_back({8'hFE, 8'hFF, 8'h00});
      settle();

      // wider frame with an oversized height, cut to two rows after the first row,
      // then one more full frame; no idling here, the receiver hold-off lands in
      // the second row
      set_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
      write_reg(CSR_WIDTH, PRESS_WIDTH);
      write_reg(CSR_HEIGHT, 2047);
      write_reg(CSR_CHANNELS, 3);
      write_reg(CSR_KEEP, CSR_DATA_W'($urandom_range(1)));
      steady_flow = 1'b1;
      queue_random(PRESS_WIDTH);
      settle();
      write_reg(CSR_HEIGHT, 2);
      queue_random(3 * PRESS_WIDTH);
      settle();
      steady_flow = 1'b0;
      random_count = 0;

      // random small frames, each phase starting at the frame origin
      while (random_count < RANDOM_PIXELS) begin
         set_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
         w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
         h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 6);
         write_reg(CSR_WIDTH, with_junk(w, DIM_W));
         write_reg(CSR_HEIGHT, with_junk(h, DIM_W));
         write_reg(CSR_CHANNELS, with_junk($urandom_range(3), CNT_W));
         write_reg(CSR_KEEP, with_junk($urandom_range(1), 1));
         w = clip(width_reg, 2, MAX_WIDTH);
         h = clip(height_reg, 2, MAX_HEIGHT);
         if ($urandom_range(2) == 0) begin
            // change registers partway through a frame, then finish it
            cut = $urandom_range(1, w * h - 1);
            queue_random(cut);
            settle();
            if ($urandom_range(1))
               set_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
            if ($urandom_range(1)) write_reg(CSR_CHANNELS, CSR_DATA_W'($urandom_range(3)));
            if ($urandom_range(1)) write_reg(CSR_KEEP, CSR_DATA_W'($urandom_range(1)));
            if ($urandom_range(1)) write_reg(CSR_HEIGHT, with_junk($urandom_range(2, 6), DIM_W));
            // only a narrower width keeps every line memory read on written data
            if (w > 2 && $urandom_range(2) == 0)
               write_reg(CSR_WIDTH, CSR_DATA_W'($urandom_range(2, w - 1)));
            queue_random(pixels_left_in_frame());
         end else begin
            frames = $urandom_range(1, 3);
            queue_random(frames * w * h);
         end
         settle();
      end

      settle();
      repeat (4 * SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && filtered_due.size() == 0) begin
         $display("clamped_3x3_convolution_unit test passed");
      end else begin
         $display("clamped_3x3_convolution_unit test failed");
      end
      $finish;
   end

endmodule

// ----- clamped_3x3_convolution_unit.f -----
+incdir+rtl
rtl/c3c_pkg.sv
rtl/c3c_csr.sv
rtl/c3c_window.sv
rtl/c3c_mac.sv
rtl/clamped_3x3_convolution_unit.sv
verif/clamped_3x3_convolution_unit_tb.sv
